// File: design/utf8_byte_decoder_defines.svh
// Assertion macros shared by the UTF-8 byte decoder RTL.
`ifndef UTF8_BYTE_DECODER_DEFINES_SVH
`define UTF8_BYTE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define UBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante.
`define UBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define UBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/ubd_pkg.sv
// Types and constants of the UTF-8 byte decoder.
`default_nettype none

package ubd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Byte class boundaries
    localparam logic [BYTE_W-1:0] ASCII_END = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'd194;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'd224;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'd240;
    localparam logic [BYTE_W-1:0] LEAD_END  = 8'd245;
    localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MAX  = 8'd191;

    // Payload masks
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'b00011111;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'b00001111;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'b00000111;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'b00111111;

    // Result buffer holds the most results one byte can cause
    localparam logic [1:0] BUF_DEPTH = 2'd2;

    typedef logic [1:0] t_rem;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            error;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

// File: design/ubd_byte_if.sv
// Byte input channel of the UTF-8 byte decoder.
`default_nettype none

interface ubd_byte_if;
    import ubd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: design/ubd_result_if.sv
// Result output channel of the UTF-8 byte decoder.
`default_nettype none

interface ubd_result_if;
    import ubd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            error;
    logic            last;

    modport source (output valid, output code_point, output error, output last, input ready);
    modport sink (input valid, input code_point, input error, input last, output ready);
endinterface

`default_nettype wire

// File: design/ubd_decode.sv
// Decode logic: one byte against the sequence state, up to two results.
`default_nettype none

module ubd_decode (
    input  wire logic [ubd_pkg::BYTE_W-1:0] i_byte,
    input  wire ubd_pkg::t_rem              i_rem,
    input  wire logic [ubd_pkg::CP_W-1:0]   i_partial,
    output ubd_pkg::t_push                  o_push,
    output ubd_pkg::t_rem                   o_rem,
    output logic [ubd_pkg::CP_W-1:0]        o_partial
);
    import ubd_pkg::*;

    typedef struct packed {
        logic            hit;
        t_result         res;
        t_rem            rem;
        logic [CP_W-1:0] partial;
    } t_lead;

    // Decode a byte that arrives while no sequence is open.
    function automatic t_lead lead_dec(input logic [BYTE_W-1:0] b);
        t_lead l;
        l = '0;
        if (b < ASCII_END) begin
            l.hit            = 1'b1;
            l.res.code_point = CP_W'(b);
        end else if (b >= LEAD2_MIN && b < LEAD3_MIN) begin
            l.rem     = 2'd1;
            l.partial = CP_W'(b & MASK_LEAD2) << 6;
        end else if (b >= LEAD3_MIN && b < LEAD4_MIN) begin
            l.rem     = 2'd2;
            l.partial = CP_W'(b & MASK_LEAD3) << 12;
        end else if (b >= LEAD4_MIN && b < LEAD_END) begin
            l.rem     = 2'd3;
            l.partial = CP_W'(b & MASK_LEAD4) << 18;
        end else begin
            l.hit       = 1'b1;
            l.res.error = 1'b1;
        end
        return l;
    endfunction

    t_lead           lead;
    logic            is_cont;
    logic [CP_W-1:0] cont_bits;
    logic [CP_W-1:0] merged;

    assign lead      = lead_dec(i_byte);
    assign is_cont   = (i_byte >= CONT_MIN) && (i_byte <= CONT_MAX);
    assign cont_bits = CP_W'(i_byte & MASK_CONT);

    // Place the six new bits by how many continuation bytes remain.
    always_comb begin
        unique case (i_rem)
            2'd3:    merged = i_partial | (cont_bits << 12);
            2'd2:    merged = i_partial | (cont_bits << 6);
            default: merged = i_partial | cont_bits;
        endcase
    end

    always_comb begin
        o_push    = '0;
        o_rem     = i_rem;
        o_partial = i_partial;
        if (i_rem == 2'd0) begin
            o_push.count    = {1'b0, lead.hit};
            o_push.res0     = lead.res;
            o_push.res0.last = 1'b1;
            o_rem           = lead.rem;
            o_partial       = lead.partial;
        end else if (is_cont) begin
            if (i_rem == 2'd1) begin
                o_push.count           = 2'd1;
                o_push.res0.code_point = merged;
                o_push.res0.last       = 1'b1;
                o_rem                  = 2'd0;
                o_partial              = '0;
            end else begin
                o_rem     = i_rem - 2'd1;
                o_partial = merged;
            end
        end else begin
            // Missing continuation: flag it, then decode the byte as a lead.
            o_push.res0.error = 1'b1;
            o_push.res0.last  = !lead.hit;
            o_push.res1       = lead.res;
            o_push.res1.last  = 1'b1;
            o_push.count      = lead.hit ? 2'd2 : 2'd1;
            o_rem             = lead.rem;
            o_partial         = lead.partial;
        end
    end

endmodule

`default_nettype wire

// File: design/ubd_result_buf.sv
// Two-entry result buffer between the decode register and the output channel.
`default_nettype none

module ubd_result_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ubd_pkg::t_push i_push,
    input  wire logic           i_pop,
    output ubd_pkg::t_result    o_head,
    output logic                o_head_valid,
    output logic [1:0]          o_count
);
    import ubd_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;
    logic [1:0] base;
    t_result    shifted0;

    // Drop the head first, then append behind what remains.
    assign base     = r_cnt - {1'b0, i_pop};
    assign shifted0 = i_pop ? r_q1 : r_q0;
    assign n_cnt    = base + i_push.count;

    always_comb begin
        unique case (base)
            2'd0: begin
                n_q0 = i_push.res0;
                n_q1 = i_push.res1;
            end
            2'd1: begin
                n_q0 = shifted0;
                n_q1 = i_push.res0;
            end
            default: begin
                n_q0 = shifted0;
                n_q1 = r_q1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_head       = r_q0;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_count      = r_cnt;

endmodule

`default_nettype wire

// File: design/utf8_byte_decoder.sv
// Top level of the UTF-8 byte decoder.
//
// Usage: feed raw UTF-8 bytes on i_byte_ch, one beat per byte; decoded code
// points come out on o_result_ch, one beat per result, with error and last.
// Both channels use valid/ready; a beat moves on a rising edge with both high.
// A byte yields no result (sequence still open), one result, or two results
// (an error for a missing continuation byte, then the byte's own decode).
// A byte accepted into the input register is decoded from there, and its
// results are written into the result buffer, whose head drives the output.
// Throughput: one byte per cycle while the receiver takes results; a byte
// that causes two results waits in the input register until the two-entry
// result buffer is empty, as only an empty buffer can take both.
// Reset (i_rst_n low at a clock edge) empties the input register and the
// result buffer and leaves the decoder waiting for a lead byte.
// Receiver stall: results wait in the buffer, the input register holds its
// byte once the buffer cannot take its results, and ready is low while it holds.
// The input ready depends on registered state only.
`default_nettype none

`include "utf8_byte_decoder_defines.svh"

module utf8_byte_decoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ubd_byte_if.sink     i_byte_ch,
    ubd_result_if.source o_result_ch
);
    import ubd_pkg::*;

    // Input register and sequence state
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_rem              r_rem;
    logic [CP_W-1:0]   r_partial;

    t_push             dec_push;
    t_push             buf_push;
    t_rem              dec_rem;
    logic [CP_W-1:0]   dec_partial;
    t_result           head;
    logic              head_valid;
    logic [1:0]        buf_count;
    logic              proceed;
    logic              pop;

    ubd_decode u_decode (
        .i_byte    (r_in_byte),
        .i_rem     (r_rem),
        .i_partial (r_partial),
        .o_push    (dec_push),
        .o_rem     (dec_rem),
        .o_partial (dec_partial)
    );

    // Advance the held byte only when all its results fit in the buffer.
    assign proceed = r_in_valid && (dec_push.count <= (BUF_DEPTH - buf_count));
    assign i_byte_ch.ready = !r_in_valid || proceed;

    always_comb begin
        buf_push = dec_push;
        if (!proceed) begin
            buf_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_rem      <= '0;
            r_partial  <= '0;
        end else begin
            if (i_byte_ch.ready) begin
                r_in_valid <= i_byte_ch.valid;
            end
            if (proceed) begin
                r_rem     <= dec_rem;
                r_partial <= dec_partial;
            end
        end
    end

    // Load the byte payload on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_byte_ch.valid && i_byte_ch.ready) begin
            r_in_byte <= i_byte_ch.in_byte;
        end
    end

    assign pop = o_result_ch.valid && o_result_ch.ready;

    ubd_result_buf u_result_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (buf_push),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_count      (buf_count)
    );

    assign o_result_ch.valid      = head_valid;
    assign o_result_ch.code_point = head.code_point;
    assign o_result_ch.error      = head.error;
    assign o_result_ch.last       = head.last;

    `UBD_ASSERT_NOW(a_partial_idle, i_clk, i_rst_n, r_rem == 2'd0, r_partial == '0, "partial code left over while expecting a lead byte")
    `UBD_ASSERT_NEXT(a_hold_byte, i_clk, i_rst_n, r_in_valid && !proceed, r_in_valid && (r_in_byte == $past(r_in_byte)), "stalled input byte was lost or changed")
    `UBD_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, pop && !proceed, buf_count == ($past(buf_count) - 2'd1), "result buffer count did not drop on a pop")
    `UBD_ASSERT_NOW(a_buf_bound, i_clk, i_rst_n, proceed, (buf_count + dec_push.count) <= BUF_DEPTH, "result buffer overfilled")

endmodule

`default_nettype wire
